// ===== design/lzw_pkg.sv =====
`timescale 1ns / 1ps

package lzw_pkg;

    localparam int CODE_BITS_DEF = 12;
    localparam int BYTE_BITS     = 8;
    localparam int FIRST_CODE    = 256;

    // write strobes toward the dictionary memories
    typedef struct packed {
        logic h_we;
        logic b_we;
    } t_dict_wr;

endpackage

// ===== design/lzw_if.sv =====
`timescale 1ns / 1ps

interface lzw_byte_if
    import lzw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lzw_code_if
    import lzw_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] out_code;
    logic                 last_code;

    modport source (output valid, output out_code, output last_code, input ready);
    modport sink   (input valid, input out_code, input last_code, output ready);
endinterface

// ===== design/lzw_compressor.sv =====
`timescale 1ns / 1ps

// channel    dir   fields                        beat when
// i_byte_s   in    data_byte, end_of_stream      valid & ready
// o_code_s   out   out_code, last_code           valid & ready
//
// each byte after the first is looked up by a hash probe: slot read, back-pointer read, then compare
// on the two dictionary memories; each slot collision repeats those steps at the next slot;
// a miss passes through S_EMIT_PFX to emit the prefix, a last byte also through S_EMIT_LAST.
// the first byte of a stream only loads the prefix. reset needs no clearing pass.
// ready is high only between bytes; a full output register holds the emit states.

module lzw_compressor
    import lzw_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzw_byte_if.sink   i_byte_s,
    lzw_code_if.source o_code_s
);

    localparam int SLOT_BITS = CODE_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_BACK_CHK,
        S_EMIT_PFX,
        S_EMIT_LAST
    } t_state;

    t_state               r_state;
    logic [CODE_BITS-1:0] r_prefix;
    logic                 r_prefix_valid;
    logic [CODE_BITS:0]   r_next_free;
    logic [BYTE_BITS-1:0] r_byte;
    logic                 r_last;
    logic [SLOT_BITS-1:0] r_slot;
    logic                 r_key_hit;
    logic [CODE_BITS-1:0] r_cand;
    logic                 r_rng;
    logic [CODE_BITS-1:0] r_emit;
    logic                 r_out_valid;
    logic [CODE_BITS-1:0] r_out_code;
    logic                 r_out_last;

    logic [CODE_BITS-1:0] h_pfx;
    logic [BYTE_BITS-1:0] h_byte;
    logic [CODE_BITS-1:0] h_code;
    logic [SLOT_BITS-1:0] b_slot;

    t_dict_wr             w_wr;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_room;
    logic                 w_live;
    logic                 w_rng_now;
    logic [SLOT_BITS-1:0] w_hash;
    logic [CODE_BITS-1:0] w_b_raddr;
    logic [CODE_BITS-1:0] w_b_waddr;

    assign i_byte_s.ready    = (r_state == S_IDLE);
    assign w_accept          = i_byte_s.valid && i_byte_s.ready;
    assign o_code_s.valid    = r_out_valid;
    assign o_code_s.out_code = r_out_code;
    assign o_code_s.last_code = r_out_last;
    assign w_out_free        = !r_out_valid || o_code_s.ready;

    assign w_room = !r_next_free[CODE_BITS];
    // byte folded into the top bits of the slot index
    assign w_hash = SLOT_BITS'(r_prefix)
                  ^ (SLOT_BITS'(i_byte_s.data_byte) << (SLOT_BITS - BYTE_BITS));

    // candidate code must be learned in this stream before its back pointer is trusted
    assign w_rng_now = (h_code >= CODE_BITS'(FIRST_CODE))
                    && ({1'b0, h_code} < r_next_free);
    assign w_b_raddr = w_rng_now ? (h_code - CODE_BITS'(FIRST_CODE)) : '0;
    assign w_b_waddr = r_next_free[CODE_BITS-1:0] - CODE_BITS'(FIRST_CODE);
    assign w_live    = r_rng && (b_slot == r_slot);

    always_comb begin
        w_wr.h_we = (r_state == S_BACK_CHK) && !w_live && w_room;
        w_wr.b_we = w_wr.h_we;
    end

    lzw_dict #(
        .CODE_BITS(CODE_BITS)
    ) u_dict (
        .i_clk    (i_clk),
        .i_wr     (w_wr),
        .i_h_addr (r_slot),
        .i_h_wpfx (r_prefix),
        .i_h_wbyte(r_byte),
        .i_h_wcode(r_next_free[CODE_BITS-1:0]),
        .o_h_pfx  (h_pfx),
        .o_h_byte (h_byte),
        .o_h_code (h_code),
        .i_b_raddr(w_b_raddr),
        .i_b_waddr(w_b_waddr),
        .i_b_wdata(r_slot),
        .o_b_slot (b_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_prefix       <= '0;
            r_prefix_valid <= 1'b0;
            r_next_free    <= (CODE_BITS + 1)'(FIRST_CODE);
            r_out_valid    <= 1'b0;
        end else begin
            // the emit states load the output register themselves
            if (o_code_s.ready && r_state != S_EMIT_PFX && r_state != S_EMIT_LAST) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_byte <= i_byte_s.data_byte;
                        r_last <= i_byte_s.end_of_stream;
                        if (!r_prefix_valid) begin
                            r_prefix       <= CODE_BITS'(i_byte_s.data_byte);
                            r_prefix_valid <= 1'b1;
                            if (i_byte_s.end_of_stream) begin
                                r_state <= S_EMIT_LAST;
                            end
                        end else begin
                            r_slot  <= w_hash;
                            r_state <= S_SLOT_RD;
                        end
                    end
                end
                S_SLOT_RD: begin
                    r_state <= S_SLOT_CHK;
                end
                S_SLOT_CHK: begin
                    r_key_hit <= (h_pfx == r_prefix) && (h_byte == r_byte);
                    r_cand    <= h_code;
                    r_rng     <= w_rng_now;
                    r_state   <= S_BACK_CHK;
                end
                S_BACK_CHK: begin
                    if (w_live && r_key_hit) begin
                        r_prefix <= r_cand;
                        r_state  <= r_last ? S_EMIT_LAST : S_IDLE;
                    end else if (w_live) begin
                        // slot taken by another string, linear probe
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_SLOT_RD;
                    end else begin
                        r_emit   <= r_prefix;
                        r_prefix <= CODE_BITS'(r_byte);
                        if (w_room) begin
                            r_next_free <= r_next_free + 1'b1;
                        end
                        r_state <= S_EMIT_PFX;
                    end
                end
                S_EMIT_PFX: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_code  <= r_emit;
                        r_out_last  <= 1'b0;
                        r_state     <= r_last ? S_EMIT_LAST : S_IDLE;
                    end
                end
                S_EMIT_LAST: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_code     <= r_prefix;
                        r_out_last     <= 1'b1;
                        r_prefix       <= '0;
                        r_prefix_valid <= 1'b0;
                        r_next_free    <= (CODE_BITS + 1)'(FIRST_CODE);
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_next_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free >= (CODE_BITS + 1)'(FIRST_CODE))
        && (r_next_free <= (CODE_BITS + 1)'(2 ** CODE_BITS)))
        else $error("next free code out of range");

    a_learn_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.b_we |-> (w_room && !(w_live && r_key_hit)))
        else $error("dictionary write without room or on a hit");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_LAST && w_out_free)
        |=> (!r_prefix_valid && r_out_valid && r_out_last
             && r_next_free == (CODE_BITS + 1)'(FIRST_CODE)))
        else $error("final code did not close the stream");

endmodule

// ===== design/lzw_dict.sv =====
`timescale 1ns / 1ps

module lzw_dict
    import lzw_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                 i_clk,
    input  t_dict_wr             i_wr,
    input  logic [CODE_BITS:0]   i_h_addr,
    input  logic [CODE_BITS-1:0] i_h_wpfx,
    input  logic [BYTE_BITS-1:0] i_h_wbyte,
    input  logic [CODE_BITS-1:0] i_h_wcode,
    output logic [CODE_BITS-1:0] o_h_pfx,
    output logic [BYTE_BITS-1:0] o_h_byte,
    output logic [CODE_BITS-1:0] o_h_code,
    input  logic [CODE_BITS-1:0] i_b_raddr,
    input  logic [CODE_BITS-1:0] i_b_waddr,
    input  logic [CODE_BITS:0]   i_b_wdata,
    output logic [CODE_BITS:0]   o_b_slot
);

    localparam int SLOT_BITS  = CODE_BITS + 1;
    localparam int HASH_DEPTH = 2 ** SLOT_BITS;
    localparam int DICT_DEPTH = 2 ** CODE_BITS - FIRST_CODE;
    localparam int H_BITS     = 2 * CODE_BITS + BYTE_BITS;

    // hash slots: {prefix, byte, code}; a slot counts only if its code points back to it
    bit   [H_BITS-1:0]    r_hash_mem [HASH_DEPTH];
    // back pointer from each learned code to the slot that holds it
    logic [SLOT_BITS-1:0] r_back_mem [DICT_DEPTH];
    logic [H_BITS-1:0]    r_h_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.h_we) begin
            r_hash_mem[i_h_addr] <= {i_h_wpfx, i_h_wbyte, i_h_wcode};
        end
        r_h_rdata <= r_hash_mem[i_h_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.b_we) begin
            r_back_mem[i_b_waddr] <= i_b_wdata;
        end
        o_b_slot <= r_back_mem[i_b_raddr];
    end

    assign o_h_pfx  = r_h_rdata[H_BITS-1 -: CODE_BITS];
    assign o_h_byte = r_h_rdata[CODE_BITS +: BYTE_BITS];
    assign o_h_code = r_h_rdata[CODE_BITS-1:0];

endmodule
